@@ sv/aco_pkg.sv @@
package aco_pkg;

  localparam int ACO_CHANNELS = 8;
  localparam int CH_W         = 3;
  localparam int RAW_W        = 16;
  localparam int SAMPLE_SHIFT = 3;
  localparam int SMP_W        = RAW_W - SAMPLE_SHIFT;
  localparam int SUM_W        = 18;
  localparam int CNT_W        = 5;
  localparam int AVG_W        = 13;

  localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(17);

  typedef enum logic [0:0] {
    OP_ACCUM = 1'b0,
    OP_READ  = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

@@ sv/aco_in_if.sv @@
interface aco_in_if import aco_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [CH_W-1:0]  channel;
  logic [RAW_W-1:0] raw_word;

  modport source(output valid, opcode, channel, raw_word, input ready);
  modport sink(input valid, opcode, channel, raw_word, output ready);
endinterface

@@ sv/aco_out_if.sv @@
interface aco_out_if import aco_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AVG_W-1:0] average;
  logic [CH_W-1:0]  channel_echo;

  modport source(output valid, average, channel_echo, input ready);
  modport sink(input valid, average, channel_echo, output ready);
endinterface

@@ sv/aco_ser_add.sv @@
// Bit-serial adder, LSB first, one bit per cycle.
module aco_ser_add import aco_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] a,
  input  logic [SUM_W-1:0] b,
  output logic             done,
  output logic [SUM_W-1:0] sum
);

  localparam int BC_W = $clog2(SUM_W);

  logic [SUM_W-1:0] a_sr_r, b_sr_r, s_sr_r;
  logic             carry_r;
  logic [BC_W-1:0]  bit_cnt_r;
  logic             busy_r, done_r;
  logic             sbit, cout;

  assign sbit = a_sr_r[0] ^ b_sr_r[0] ^ carry_r;
  assign cout = (a_sr_r[0] & b_sr_r[0]) | (carry_r & (a_sr_r[0] ^ b_sr_r[0]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        bit_cnt_r <= BC_W'(SUM_W - 1);
      end else if (busy_r) begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_sr_r  <= a;
      b_sr_r  <= b;
      carry_r <= 1'b0;
    end else if (busy_r) begin
      a_sr_r  <= a_sr_r >> 1;
      b_sr_r  <= b_sr_r >> 1;
      s_sr_r  <= {sbit, s_sr_r[SUM_W-1:1]};
      carry_r <= cout;
    end
  end

  assign done = done_r;
  assign sum  = s_sr_r;

endmodule

@@ sv/aco_ser_div.sv @@
// Restoring divider, one quotient bit per cycle, dividend MSB first.
module aco_ser_div import aco_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic             done,
  output logic [SUM_W-1:0] quotient
);

  localparam int BC_W = $clog2(SUM_W);

  logic [SUM_W-1:0] dq_r;     // dividend shifts out, quotient shifts in
  logic [CNT_W-1:0] rem_r;
  logic [CNT_W-1:0] div_r;
  logic [BC_W-1:0]  bit_cnt_r;
  logic             busy_r, done_r;
  logic [CNT_W:0]   partial, diff;
  logic             ge;

  assign partial = {rem_r, dq_r[SUM_W-1]};
  assign ge      = partial >= {1'b0, div_r};
  assign diff    = partial - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      bit_cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r    <= 1'b1;
        bit_cnt_r <= BC_W'(SUM_W - 1);
      end else if (busy_r) begin
        bit_cnt_r <= bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= {dq_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : partial[CNT_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = dq_r;

endmodule

@@ sv/adc_channel_oversample_averager_top.sv @@
// Oversampling averager for up to CHANNELS converter channels.
// in_ch (valid/ready) carries opcode, channel and raw_word. An accumulate
// item adds raw_word >> 3 to the channel's running sum through a bit-serial
// adder (one bit per cycle), restarting the channel first when
// its count has reached sample_limit. A read item divides sum by count in a
// restoring divider (one quotient bit per cycle), clears the
// channel and returns one transfer on out_ch (average, channel_echo); an
// empty channel reports 0. Out-of-range channels: accumulate is dropped,
// read returns 0 and leaves state alone.
// in_ch is ready only in the idle state, so a new item is taken only after the
// current one has finished its serial steps and its write back or result load.
// out_ch valid rises once the divider is done and the output register loads.
// The result sits in an output register, so in_ch is ready again while the
// result still waits; a read that finishes while out_ch is stalled holds
// in the divider until the register frees up.
// cfg_we/cfg_wdata write sample_limit; the user must write it only while the
// block is idle, as the block itself does not enforce this. Reset (rst_n,
// synchronous): sums and counts zero, sample_limit 17, no result pending.
module adc_channel_oversample_averager_top import aco_pkg::*; #(
  parameter int CHANNELS = ACO_CHANNELS
) (
  input  logic             clk,
  input  logic             rst_n,
  aco_in_if.sink           in_ch,
  aco_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state_r, state_nxt;

  logic [SUM_W-1:0] sum_r [CHANNELS];
  logic [CNT_W-1:0] cnt_r [CHANNELS];
  logic [CNT_W-1:0] limit_r;

  logic [IDX_W-1:0] idx_r;
  logic [CH_W-1:0]  ch_r;
  logic             zero_r;

  logic             out_valid_r;
  logic [AVG_W-1:0] avg_r;
  logic [CH_W-1:0]  echo_r;

  logic             in_xfer, ch_ok, restart;
  logic [IDX_W-1:0] in_idx;
  logic [SUM_W-1:0] cur_sum;
  logic [CNT_W-1:0] cur_cnt;
  logic             add_start, div_start, add_done, div_done;
  logic [SUM_W-1:0] add_sum, quot;
  logic             out_free, load_out;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign ch_ok    = 32'(in_ch.channel) < CHANNELS;
  assign in_idx   = IDX_W'(in_ch.channel);
  assign cur_sum  = ch_ok ? sum_r[in_idx] : '0;
  assign cur_cnt  = ch_ok ? cnt_r[in_idx] : '0;
  assign restart  = cur_cnt >= limit_r;
  assign out_free = !out_valid_r || out_ch.ready;

  assign add_start = in_xfer && (in_ch.opcode == OP_ACCUM) && ch_ok;
  assign div_start = in_xfer && (in_ch.opcode == OP_READ);

  aco_ser_add u_add (
    .clk   (clk),
    .rst_n (rst_n),
    .start (add_start),
    .a     (restart ? '0 : cur_sum),
    .b     (SUM_W'(in_ch.raw_word >> SAMPLE_SHIFT)),
    .done  (add_done),
    .sum   (add_sum)
  );

  aco_ser_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cur_sum),
    .divisor  (cur_cnt),
    .done     (div_done),
    .quotient (quot)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (add_start) begin
          state_nxt = ST_ACC;
        end else if (div_start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_ACC: begin
        if (add_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (out_free) begin
            load_out  = 1'b1;
            state_nxt = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // channel state: count updates at transfer, sum when the adder finishes; a read clears both at transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i] <= '0;
        cnt_r[i] <= '0;
      end
    end else begin
      if (add_start) begin
        cnt_r[in_idx] <= restart ? CNT_W'(1) : cur_cnt + 1'b1;
      end else if (div_start && ch_ok) begin
        sum_r[in_idx] <= '0;
        cnt_r[in_idx] <= '0;
      end
      if (add_done) begin
        sum_r[idx_r] <= add_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      idx_r  <= in_idx;
      ch_r   <= in_ch.channel;
      zero_r <= !ch_ok || (cur_cnt == '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      avg_r  <= zero_r ? '0 : quot[AVG_W-1:0];
      echo_r <= ch_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.average      = avg_r;
  assign out_ch.channel_echo = echo_r;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import aco_pkg::*;

  // Margin for an item still in the block to finish before touching
  // sample_limit and before the final verdict.
  localparam int DRAIN_CYCLES = 40;
  // Slowest legal run: ~1450 transfers, each with the block's serial steps plus
  // sender gaps and long receiver stalls. Several times over.
  localparam int unsigned CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 175;
  localparam int N_PHASES = 8;

  typedef struct packed {
    logic [AVG_W-1:0] average;
    logic [CH_W-1:0]  channel;
  } avg_result_t;

  // Tracks per-channel sum/count and queues the averages that reads produce.
  class average_tracker;
    logic [SUM_W-1:0] chan_sum [ACO_CHANNELS];
    logic [CNT_W-1:0] chan_count [ACO_CHANNELS];
    logic [CNT_W-1:0] limit;
    avg_result_t      pending_avgs [$];
    int unsigned      mismatches;

    function new();
      foreach (chan_sum[i]) begin
        chan_sum[i]   = '0;
        chan_count[i] = '0;
      end
      limit      = LIMIT_RESET;
      mismatches = 0;
    endfunction

    function void note_transfer(opcode_t op, logic [CH_W-1:0] ch, logic [RAW_W-1:0] word);
      avg_result_t want;
      if (op == OP_ACCUM) begin
        if (int'(ch) >= ACO_CHANNELS) return;
        // channel full: restart before adding
        if (chan_count[ch] >= limit) begin
          chan_sum[ch]   = '0;
          chan_count[ch] = '0;
        end
        chan_sum[ch]   = chan_sum[ch] + SUM_W'(word >> SAMPLE_SHIFT);
        chan_count[ch] = chan_count[ch] + 1'b1;
      end else begin
        want.average = '0;
        want.channel = ch;
        if (int'(ch) < ACO_CHANNELS) begin
          if (chan_count[ch] != '0)
            want.average = AVG_W'(chan_sum[ch] / chan_count[ch]);
          chan_sum[ch]   = '0;
          chan_count[ch] = '0;
        end
        pending_avgs.push_back(want);
      end
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_average(logic [AVG_W-1:0] avg, logic [CH_W-1:0] ch);
      avg_result_t want;
      if (pending_avgs.size() == 0) begin
        report_mismatch($sformatf("unexpected result ch %0d avg %0d", ch, avg));
        return;
      end
      want = pending_avgs.pop_front();
      if (ch !== want.channel)
        report_mismatch($sformatf("channel_echo %0d, want %0d", ch, want.channel));
      if (avg !== want.average)
        report_mismatch($sformatf("ch %0d average %0d, want %0d", want.channel, avg,
                                  want.average));
    endtask

    function int pending();
      return pending_avgs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CNT_W-1:0] cfg_wdata;

  aco_in_if  in_ch ();
  aco_out_if out_ch ();

  average_tracker tracker;

  // Idle/stall rates in percent per cycle, changed between phases only.
  int send_idle_pct;
  int recv_stall_pct;
  int stall_left;
  int unsigned cycle_cnt = 0;

  adc_channel_oversample_averager_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 8 ns period
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Monitors. Both channels are sampled at the edge, so the values seen are
  // the ones that were present when the transfer happened.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      tracker.note_transfer(opcode_t'(in_ch.opcode), in_ch.channel, in_ch.raw_word);
    if (rst_n && out_ch.valid && out_ch.ready)
      tracker.check_average(out_ch.average, out_ch.channel_echo);
  end

  // Result-side backpressure: per-cycle random stalls, plus the odd long
  // stall so that a finished read has to park in the divider.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (recv_stall_pct != 0 && $urandom_range(0, 63) == 0) begin
      stall_left   <= $urandom_range(5, 60);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Mostly random words, with heavy weight on the extremes and on small words
  // (0 to 15) that the 3-bit shift leaves at 0 or 1.
  function automatic logic [RAW_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return RAW_W'($urandom_range(0, 15));
      default: return RAW_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // One transfer on in_ch. valid stays high between back-to-back items and
  // is only lowered when a gap is taken before the next one.
  task automatic send_item(opcode_t op, logic [CH_W-1:0] ch, logic [RAW_W-1:0] word);
    int gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      while ($urandom_range(0, 99) < send_idle_pct)
        gap++;
      if ($urandom_range(0, 15) == 0)
        gap += $urandom_range(1, 40);
    end
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.channel  <= ch;
    in_ch.raw_word <= word;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Quiesce, then write sample_limit. Accumulates give no result, so after
  // the last average arrives the block may still be busy: wait it out.
  task automatic write_limit(logic [CNT_W-1:0] value);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.limit = value;
  endtask

  // Random traffic. Most of it is runs of samples on one channel, usually followed
  // by a read; run lengths straddle the current limit so restarts happen. The
  // rest is single random items.
  task automatic run_phase(int n_items);
    int sent;
    int n;
    bit flood;
    logic [CH_W-1:0] ch;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 9) < 7) begin
        ch    = CH_W'($urandom_range(0, ACO_CHANNELS - 1));
        flood = ($urandom_range(0, 7) == 0);
        if (flood)
          n = (tracker.limit == '0) ? 3 : int'(tracker.limit);
        else if ($urandom_range(0, 3) == 0)
          n = $urandom_range(int'(tracker.limit), int'(tracker.limit) + 3);
        else
          n = $urandom_range(1, 6);
        repeat (n)
          send_item(OP_ACCUM, ch, flood ? '1 : pick_word());
        sent += n;
        if ($urandom_range(0, 9) != 0) begin
          send_item(OP_READ, ch, RAW_W'($urandom_range(0, 65535)));
          sent++;
        end
      end else begin
        send_item(opcode_t'($urandom_range(0, 1)),
                  CH_W'($urandom_range(0, ACO_CHANNELS - 1)), pick_word());
        sent++;
      end
    end
  endtask

  initial begin
    logic [CNT_W-1:0] phase_limit [N_PHASES];
    int               phase_mode  [N_PHASES];

    tracker = new();
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = 1'b0;
    in_ch.channel  = '0;
    in_ch.raw_word = '0;
    out_ch.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_left     = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, limit at its reset value, no idling.
    send_item(OP_READ, 3'd0, 16'h0000);     // empty channel reads 0
    send_item(OP_ACCUM, 3'd7, 16'hFFFF);
    send_item(OP_ACCUM, 3'd7, 16'hFFFF);
    send_item(OP_READ, 3'd7, 16'h0000);     // full-scale mean
    send_item(OP_ACCUM, 3'd3, 16'h0000);
    send_item(OP_READ, 3'd3, 16'hFFFF);     // raw_word ignored on read
    send_item(OP_ACCUM, 3'd1, 16'h0007);    // shifts to zero
    send_item(OP_ACCUM, 3'd1, 16'h0008);
    send_item(OP_ACCUM, 3'd1, 16'h0010);
    send_item(OP_READ, 3'd1, 16'h0000);
    send_item(OP_ACCUM, 3'd5, 16'hFFF8);
    send_item(OP_ACCUM, 3'd5, 16'h0001);
    send_item(OP_READ, 3'd5, 16'h0000);     // mean truncates
    send_item(OP_READ, 3'd5, 16'h0000);     // cleared by the previous read
    send_item(OP_ACCUM, 3'd2, 16'h1234);
    send_item(OP_ACCUM, 3'd6, 16'hABCD);
    send_item(OP_ACCUM, 3'd4, 16'h8000);
    send_item(OP_ACCUM, 3'd0, 16'h7FFF);
    send_item(OP_READ, 3'd4, 16'h0000);
    send_item(OP_ACCUM, 3'd2, 16'h5555);
    send_item(OP_ACCUM, 3'd2, 16'hAAAA);

    // Limit lowered below channel 2's count: its next sample restarts it.
    write_limit(5'd1);
    send_item(OP_ACCUM, 3'd2, 16'h0808);
    send_item(OP_READ, 3'd2, 16'h0000);

    // Phase plan. Modes: 0 no idling, 1 sender idles, 2 receiver stalls,
    // 3 both. Limit zero makes every sample restart its channel.
    phase_limit = '{5'd31, 5'd0, 5'd2, 5'd31, LIMIT_RESET,
                    CNT_W'($urandom_range(1, 30)), 5'd1, CNT_W'($urandom_range(1, 30))};
    phase_mode  = '{0, 1, 2, 3, 3, 2, 1, 0};

    for (int p = 0; p < N_PHASES; p++) begin
      write_limit(phase_limit[p]);
      case (phase_mode[p])
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      run_phase(PHASE_ITEMS);
    end

    // Drain: every queued average must come out, then a quiet tail in which
    // any stray result would be flagged by the monitor.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
